// ===== rtl/can_frame_change_filter_top_assert.svh =====
// Assertion macros for the CAN frame change filter.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef CAN_FRAME_CHANGE_FILTER_TOP_ASSERT_SVH
`define CAN_FRAME_CHANGE_FILTER_TOP_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define CFCF_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A consequence that must hold in the cycle after the antecedent.
`define CFCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cfcf_pkg.sv =====
// Shared types, constants and helpers for the CAN frame change filter.
// No dependencies; the interfaces, front, queue, back and top import this package.
package cfcf_pkg;

  // Table and compare window sizes.
  localparam int unsigned TABLE_ENTRIES = 48;
  localparam int unsigned COMPARE_BYTES = 8;

  // Field widths.
  localparam int unsigned ID_W      = 29;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned NUM_BYTES = 8;
  localparam int unsigned DATA_W    = 8 * NUM_BYTES;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned REP_W     = 16;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned OC_W      = 3;

  // Table addressing.
  localparam int unsigned ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_ENTRIES + 1);

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = ID_W;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WATCH_ID = CFG_IDX_W'(1);

  // Message identifiers and compare limits.
  localparam logic [ID_W-1:0] ID_SPEED  = 29'h02F8_3201;
  localparam int unsigned     SPEED_CMP = 4;
  localparam int unsigned     MAX_LEN   = NUM_BYTES;
  localparam int unsigned     CMP_LIMIT = (COMPARE_BYTES > NUM_BYTES) ? NUM_BYTES
                                                                      : COMPARE_BYTES;
  localparam int unsigned     NUM_KNOWN = 6;
  localparam logic [ID_W-1:0] KNOWN_IDS [NUM_KNOWN] = '{
    29'h02F8_3200, 29'h02F8_3201, 29'h02F8_3203,
    29'h0310_6300, 29'h0310_6301, 29'h0310_6302
  };

  // Queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF      = 2'd0,
    MODE_SUPPRESS = 2'd1,
    MODE_KNOWN    = 2'd2,
    MODE_ALL      = 2'd3
  } mode_e;

  typedef enum logic [OC_W-1:0] {
    OC_REMOTE    = 3'd0,
    OC_OFF       = 3'd1,
    OC_FILTERED  = 3'd2,
    OC_NEW       = 3'd3,
    OC_CHANGED   = 3'd4,
    OC_UNCHANGED = 3'd5,
    OC_FULL      = 3'd6,
    OC_UNTRACKED = 3'd7
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } state_e;

  typedef struct packed {
    mode_e           mode;
    logic [ID_W-1:0] watch;
  } cfg_t;

  // One classified word as it travels from front to back.
  typedef struct packed {
    logic                 lookup;
    outcome_e             outcome;
    logic                 report;
    logic                 speed;
    logic                 known;
    logic [ID_W-1:0]      id;
    logic [LEN_W-1:0]     len;
    logic [NUM_BYTES-1:0] bytes_mask;
    logic [DATA_W-1:0]    data;
  } item_t;

  // One table entry as held in the RAM.
  typedef struct packed {
    logic [ID_W-1:0]   ident;
    logic [REP_W-1:0]  repeats;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] bytes;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              report;
    outcome_e          outcome;
    logic              slot_valid;
    logic [SLOT_W-1:0] slot;
    logic [REP_W-1:0]  repeat_count;
    logic              speed_frame;
    logic              known_id;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0] used;
    logic             table_full;
  } back_sts_t;

  // Widens a per-byte enable into a bit mask over the payload.
  function automatic logic [DATA_W-1:0] expand_mask(input logic [NUM_BYTES-1:0] bm);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < NUM_BYTES; b++) begin
      m[8*b +: 8] = {8{bm[b]}};
    end
    return m;
  endfunction

endpackage

// ===== rtl/cfcf_frame_if.sv =====
// Channel interface carrying one received CAN frame word.
// Depends on cfcf_pkg for the field widths.
interface cfcf_frame_if;
  import cfcf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ID_W-1:0]       frame_id;
  logic                  remote_request;
  logic [LEN_W-1:0]      byte_count;
  logic [DATA_W-1:0]     payload;

  modport source (output valid, frame_id, remote_request, byte_count, payload,
                  input ready);
  modport sink   (input valid, frame_id, remote_request, byte_count, payload,
                  output ready);
endinterface

// ===== rtl/cfcf_result_if.sv =====
// Channel interface carrying one classification result word.
// Depends on cfcf_pkg for the field widths.
interface cfcf_result_if;
  import cfcf_pkg::*;

  logic              valid;
  logic              ready;
  logic              report;
  logic [OC_W-1:0]   outcome;
  logic              slot_valid;
  logic [SLOT_W-1:0] slot;
  logic [REP_W-1:0]  repeat_count;
  logic              speed_frame;
  logic              known_id;

  modport source (output valid, report, outcome, slot_valid, slot, repeat_count,
                  speed_frame, known_id, input ready);
  modport sink   (input valid, report, outcome, slot_valid, slot, repeat_count,
                  speed_frame, known_id, output ready);
endinterface

// ===== rtl/cfcf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cfcf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cfcf_front.sv =====
// Front end: accepts frame words and classifies them against the mode registers.
// Depends on cfcf_pkg and cfcf_frame_if.
module cfcf_front (
  input  cfcf_pkg::cfg_t cfg_i,
  cfcf_frame_if.sink     frame_i,
  output logic           push_valid_o,
  output cfcf_pkg::item_t push_item_o,
  input  logic           push_ready_i
);
  import cfcf_pkg::*;

  logic                 known;
  logic                 is_speed_id;
  logic [LEN_W-1:0]     len_sat;
  logic [LEN_W-1:0]     cmp_lim;
  logic [LEN_W-1:0]     cmp_n;
  logic [NUM_BYTES-1:0] bmask;

  // A frame is taken whenever the queue has room.
  assign frame_i.ready = push_ready_i;
  assign push_valid_o  = frame_i.valid;

  // Known identifier match.
  always_comb begin
    known = 1'b0;
    for (int k = 0; k < NUM_KNOWN; k++) begin
      if (frame_i.frame_id == KNOWN_IDS[k]) begin
        known = 1'b1;
      end
    end
  end

  // Length saturation and the byte window that is compared.
  assign is_speed_id = (frame_i.frame_id == ID_SPEED);
  assign len_sat = (frame_i.byte_count > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN)
                                                          : frame_i.byte_count;
  assign cmp_lim = is_speed_id ? LEN_W'(SPEED_CMP) : LEN_W'(CMP_LIMIT);
  assign cmp_n   = (len_sat < cmp_lim) ? len_sat : cmp_lim;

  always_comb begin
    bmask = '0;
    for (int b = 0; b < NUM_BYTES; b++) begin
      bmask[b] = (LEN_W'(b) < cmp_n);
    end
  end

  // Classification; order decides which gate applies first.
  always_comb begin
    push_item_o            = '0;
    push_item_o.id         = frame_i.frame_id;
    push_item_o.len        = len_sat;
    push_item_o.bytes_mask = bmask;
    push_item_o.data       = frame_i.payload;
    push_item_o.known      = known;
    push_item_o.speed      = is_speed_id && !frame_i.remote_request;
    push_item_o.lookup     = 1'b0;
    push_item_o.report     = 1'b0;
    push_item_o.outcome    = OC_UNTRACKED;
    priority if (frame_i.remote_request) begin
      push_item_o.outcome = OC_REMOTE;
    end else if (cfg_i.mode == MODE_OFF) begin
      push_item_o.outcome = OC_OFF;
    end else if ((cfg_i.watch != '0) && (frame_i.frame_id != cfg_i.watch)) begin
      push_item_o.outcome = OC_FILTERED;
    end else if (cfg_i.mode == MODE_SUPPRESS) begin
      push_item_o.lookup = 1'b1;
    end else begin
      push_item_o.outcome = OC_UNTRACKED;
      push_item_o.report  = known || (cfg_i.mode == MODE_ALL);
    end
  end

endmodule

// ===== rtl/cfcf_queue.sv =====
// Short register queue of classified words between front and back.
// Depends on cfcf_pkg.
module cfcf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  cfcf_pkg::item_t push_item_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output cfcf_pkg::item_t pop_item_o,
  input  logic            pop_i
);
  import cfcf_pkg::*;

  item_t              slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;
  logic               do_push, do_pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = slots_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== rtl/cfcf_back.sv =====
// Back end: scans the identifier table, updates entries and drives results.
// Depends on cfcf_pkg, cfcf_result_if and cfcf_ram.
module cfcf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  input  cfcf_pkg::item_t    pop_item_i,
  output logic               pop_o,
  cfcf_result_if.source      result_o,
  output cfcf_pkg::back_sts_t sts_o
);
  import cfcf_pkg::*;

  state_e            state_q, state_d;
  item_t             item_q, item_d;
  logic [CNT_W-1:0]  issue_q, issue_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic              chk_valid_q, chk_valid_d;
  logic [ADDR_W-1:0] chk_addr_q, chk_addr_d;
  res_t              res_q, res_d;
  res_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry, wr_entry;

  logic              hit, more, miss, out_free, changed;
  logic [DATA_W-1:0] cmp_mask, merged;
  logic [REP_W-1:0]  reps_inc;

  // Table storage.
  cfcf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  // Scan decode: one entry read per cycle, compared in the cycle after its read.
  assign hit      = (state_q == ST_SCAN) && chk_valid_q && (rd_entry.ident == item_q.id);
  assign more     = (issue_q < used_q);
  assign miss     = (state_q == ST_SCAN) && !hit && !more;
  assign out_free = !out_valid_q || result_o.ready;
  assign pop_o    = (state_q == ST_IDLE) && pop_valid_i;

  // Entry comparison and merge of the compared window.
  assign cmp_mask = expand_mask(item_q.bytes_mask);
  assign merged   = (rd_entry.bytes & ~cmp_mask) | (item_q.data & cmp_mask);
  assign changed  = (rd_entry.length != item_q.len) ||
                    (((rd_entry.bytes ^ item_q.data) & cmp_mask) != '0);
  assign reps_inc = rd_entry.repeats + 1'b1;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          state_d = pop_item_i.lookup ? ST_SCAN : ST_OUT;
        end
      end
      ST_SCAN: begin
        if (hit || miss) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and table access per state.
  always_comb begin
    item_d      = item_q;
    issue_d     = issue_q;
    used_d      = used_q;
    chk_valid_d = chk_valid_q;
    chk_addr_d  = chk_addr_q;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = chk_addr_q;
    ram_raddr   = issue_q[ADDR_W-1:0];
    wr_entry    = rd_entry;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          item_d             = pop_item_i;
          issue_d            = '0;
          chk_valid_d        = 1'b0;
          res_d.report       = pop_item_i.report;
          res_d.outcome      = pop_item_i.outcome;
          res_d.slot_valid   = 1'b0;
          res_d.slot         = '0;
          res_d.repeat_count = '0;
          res_d.speed_frame  = pop_item_i.speed;
          res_d.known_id     = pop_item_i.known;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          // Seen identifier: count a repeat, refresh the compared window.
          ram_we             = 1'b1;
          ram_waddr          = chk_addr_q;
          wr_entry.ident     = item_q.id;
          wr_entry.repeats   = reps_inc;
          wr_entry.length    = item_q.len;
          wr_entry.bytes     = merged;
          chk_valid_d        = 1'b0;
          res_d.report       = changed;
          res_d.outcome      = changed ? OC_CHANGED : OC_UNCHANGED;
          res_d.slot_valid   = 1'b1;
          res_d.slot         = SLOT_W'(chk_addr_q);
          res_d.repeat_count = reps_inc;
        end else if (more) begin
          ram_re      = 1'b1;
          ram_raddr   = issue_q[ADDR_W-1:0];
          issue_d     = issue_q + 1'b1;
          chk_valid_d = 1'b1;
          chk_addr_d  = issue_q[ADDR_W-1:0];
        end else begin
          chk_valid_d = 1'b0;
          if (used_q >= CNT_W'(TABLE_ENTRIES)) begin
            res_d.report  = 1'b0;
            res_d.outcome = OC_FULL;
          end else begin
            // New identifier goes into the next free entry.
            ram_we             = 1'b1;
            ram_waddr          = used_q[ADDR_W-1:0];
            wr_entry.ident     = item_q.id;
            wr_entry.repeats   = REP_W'(1);
            wr_entry.length    = item_q.len;
            wr_entry.bytes     = item_q.data & cmp_mask;
            used_d             = used_q + 1'b1;
            res_d.report       = 1'b1;
            res_d.outcome      = OC_NEW;
            res_d.slot_valid   = 1'b1;
            res_d.slot         = SLOT_W'(used_q);
            res_d.repeat_count = REP_W'(1);
          end
        end
      end
      ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // Output register: holds a finished word until the sink takes it.
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if ((state_q == ST_OUT) && out_free) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issue_q     <= '0;
      used_q      <= '0;
      chk_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_q     <= issue_d;
      used_q      <= used_d;
      chk_valid_q <= chk_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    chk_addr_q <= chk_addr_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.report       = out_q.report;
  assign result_o.outcome      = out_q.outcome;
  assign result_o.slot_valid   = out_q.slot_valid;
  assign result_o.slot         = out_q.slot;
  assign result_o.repeat_count = out_q.repeat_count;
  assign result_o.speed_frame  = out_q.speed_frame;
  assign result_o.known_id     = out_q.known_id;

  assign sts_o.used       = used_q;
  assign sts_o.table_full = (used_q >= CNT_W'(TABLE_ENTRIES));

endmodule

// ===== rtl/can_frame_change_filter_top.sv =====
// Top level of the CAN frame change filter: config registers, front, queue, back.
// Depends on cfcf_pkg, both channel interfaces, cfcf_front, cfcf_queue, cfcf_back
// and the assertion macro header.
//
// Usage: each word on frame_i is one received CAN frame; for each one exactly one
// word appears on result_o, in order. Both channels use valid/ready and a word
// moves at a rising edge where both are high. Configuration (log_mode, watch_id)
// is written through cfg_we_i/cfg_idx_i/cfg_wdata_i while the block is idle.
// A word that needs no table lookup goes from the queue through the back end's
// idle and output states into the output register; the back end takes no new
// word until it is through with the last. In suppress mode the table is scanned
// one entry per cycle through the registered RAM read, so a lookup takes longer
// the more entries are scanned, and longest with a full table. The back end
// works on one word at a time; the front keeps accepting into a two-word queue
// and a finished result waits in the output register while the next word is
// worked on. If the receiver stalls, the output register holds, the back end
// then stops and the queue fills, after which frame_i.ready drops.
// Reset empties the table (entries used goes to zero), sets log_mode to suppress
// unchanged frames and watch_id to zero; no clearing pass is needed.
`include "can_frame_change_filter_top_assert.svh"

module can_frame_change_filter_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  cfcf_frame_if.sink                     frame_i,
  cfcf_result_if.source                  result_o,
  input  logic                           cfg_we_i,
  input  logic [cfcf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cfcf_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import cfcf_pkg::*;

  mode_e           mode_q;
  logic [ID_W-1:0] watch_q;
  cfg_t            cfg;

  logic      push_valid, push_ready;
  item_t     push_item;
  logic      pop_valid, pop;
  item_t     pop_item;
  back_sts_t back_sts;

  logic      slot_ok, zero_ok, new_ok, full_ok;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_SUPPRESS;
      watch_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_LOG_MODE) begin
        mode_q <= mode_e'(cfg_wdata_i[MODE_W-1:0]);
      end else if (cfg_idx_i == CFG_WATCH_ID) begin
        watch_q <= cfg_wdata_i[ID_W-1:0];
      end
    end
  end

  assign cfg.mode  = mode_q;
  assign cfg.watch = watch_q;

  // Classification front end.
  cfcf_front u_front (
    .cfg_i        (cfg),
    .frame_i      (frame_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  // Queue between the two halves.
  cfcf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_i        (pop)
  );

  // Table back end.
  cfcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_o       (pop),
    .result_o    (result_o),
    .sts_o       (back_sts)
  );

  // Properties of the result word that the assertions below rely on.
  assign slot_ok = !result_o.slot_valid || (result_o.outcome == OC_NEW) ||
                   (result_o.outcome == OC_CHANGED) || (result_o.outcome == OC_UNCHANGED);
  assign zero_ok = result_o.slot_valid ||
                   ((result_o.slot == '0) && (result_o.repeat_count == '0));
  assign new_ok  = (result_o.outcome != OC_NEW) ||
                   (result_o.report && (result_o.repeat_count == REP_W'(1)));
  assign full_ok = (result_o.outcome != OC_FULL) || back_sts.table_full;

  // A named slot only comes with a table outcome.
  `CFCF_ASSERT_HOLDS(a_slot_outcome, !result_o.valid || slot_ok, "slot with a non-table outcome")

  // Without a slot the slot and repeat fields read zero.
  `CFCF_ASSERT_HOLDS(a_no_slot_zero, !result_o.valid || zero_ok, "slot fields not zero")

  // A new entry always starts at one repeat and is reported.
  `CFCF_ASSERT_HOLDS(a_new_entry, !result_o.valid || new_ok, "new entry not reported once")

  // The table only grows.
  `CFCF_ASSERT_NEXT(a_used_grows, 1'b1, back_sts.used >= $past(back_sts.used), "count went down")

  // A table-full result is only given once every entry is taken.
  `CFCF_ASSERT_HOLDS(a_full_real, !result_o.valid || full_ok, "table full with free entries")

endmodule
